[rtl/otsu_gray_binarize_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, left empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef OTSU_GRAY_BINARIZE_MACROS_SVH
`define OTSU_GRAY_BINARIZE_MACROS_SVH
`ifndef SYNTHESIS
`define OGB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ogb assertion failed");
`define OGB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ogb assertion failed");
`else
`define OGB_ASSERT_IMPL(label, ante, cons)
`define OGB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/ogb_pkg.sv]
// ----------------------------------------------------------------------------
// Otsu binarizer package
// Widths, multiplier operation codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package ogb_pkg;

  localparam int BIN_W   = 8;
  localparam int BINS    = 2 ** BIN_W;
  localparam int CNT_W   = 24;
  localparam int SUM_W   = BIN_W + CNT_W;
  localparam int AB_W    = SUM_W + CNT_W;
  localparam int NUM_W   = 2 * AB_W;
  localparam int DEN_W   = 2 * CNT_W;
  localparam int LR_W    = NUM_W + DEN_W;
  localparam int PROD_W  = NUM_W + AB_W;

  localparam logic [CNT_W-1:0] CNT_CAP = {CNT_W{1'b1}};
  localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BINS - 1);

  localparam logic [2:0] MUL_A   = 3'd0;
  localparam logic [2:0] MUL_B   = 3'd1;
  localparam logic [2:0] MUL_NUM = 3'd2;
  localparam logic [2:0] MUL_DEN = 3'd3;
  localparam logic [2:0] MUL_LHS = 3'd4;
  localparam logic [2:0] MUL_RHS = 3'd5;

  localparam logic KIND_ACC = 1'b0;
  localparam logic KIND_BIN = 1'b1;

  typedef struct packed {
    logic             acc_rd;
    logic             acc_wr;
    logic             bin_res;
    logic             clr_wr;
    logic             t_clr;
    logic             t_add;
    logic             s_init;
    logic             s_add;
    logic             rd_en;
    logic             mul_start;
    logic             mul_cap;
    logic             cmp_upd;
    logic             thr_res;
    logic             out_load;
    logic [2:0]       mul_op;
    logic [BIN_W-1:0] addr;
  } ogb_cmd_t;

  typedef struct packed {
    logic skip;
    logic mul_done;
    logic mul_busy;
    logic out_free;
  } ogb_stat_t;

endpackage

[rtl/ogb_stream_if.sv]
// ----------------------------------------------------------------------------
// Otsu binarizer channels
// Pixel request channel and result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ogb_pix_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] pixel;
  logic       last;
  modport source(output valid, output kind, output pixel, output last, input ready);
  modport sink(input valid, input kind, input pixel, input last, output ready);
endinterface

interface ogb_res_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] value;
  logic       overflow;
  modport source(output valid, output result_kind, output value, output overflow,
                 input ready);
  modport sink(input valid, input result_kind, input value, input overflow,
               output ready);
endinterface

[rtl/ogb_mul.sv]
// ----------------------------------------------------------------------------
// Otsu binarizer multiplier
// Shift-add multiplier, one multiplier bit per cycle, stops early at zero.
// ----------------------------------------------------------------------------
module ogb_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ogb_pkg::NUM_W-1:0]  mcand,
  input  logic [ogb_pkg::AB_W-1:0]   mplier,
  output logic                       busy,
  output logic                       done,
  output logic [ogb_pkg::PROD_W-1:0] product
);

  logic [ogb_pkg::PROD_W-1:0] mc;
  logic [ogb_pkg::AB_W-1:0]   mp;
  logic [ogb_pkg::PROD_W-1:0] acc;

  assign done    = busy && (mp == '0);
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc  <= ogb_pkg::PROD_W'(mcand);
      mp  <= mplier;
      acc <= '0;
    end else if (busy && (mp != '0)) begin
      if (mp[0]) begin
        acc <= acc + mc;
      end
      mc <= mc << 1;
      mp <= mp >> 1;
    end
  end

endmodule

[rtl/ogb_dp.sv]
// ----------------------------------------------------------------------------
// Otsu binarizer datapath
// Histogram memory, frame sums, variance terms, best candidate, result register.
// ----------------------------------------------------------------------------
module ogb_dp (
  input  logic              clk,
  input  logic              rst,
  input  ogb_pkg::ogb_cmd_t cmd,
  output ogb_pkg::ogb_stat_t st,
  input  logic [7:0]        pixel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [7:0]        out_value,
  output logic              out_overflow
);

  logic [ogb_pkg::CNT_W-1:0] hist [ogb_pkg::BINS];
  logic [ogb_pkg::CNT_W-1:0] rd_data;
  logic [ogb_pkg::BIN_W-1:0] rd_addr;
  logic [ogb_pkg::BIN_W-1:0] pix_reg;
  logic                      we;
  logic [ogb_pkg::BIN_W-1:0] wr_addr;
  logic [ogb_pkg::CNT_W-1:0] wr_data;

  logic [ogb_pkg::CNT_W-1:0] total;
  logic                      sat;
  logic [7:0]                thr;
  logic [ogb_pkg::SUM_W-1:0] t_sum;
  logic [ogb_pkg::CNT_W-1:0] w;
  logic [ogb_pkg::SUM_W-1:0] s;
  logic [ogb_pkg::AB_W-1:0]  a;
  logic [ogb_pkg::AB_W-1:0]  b;
  logic [ogb_pkg::AB_W-1:0]  d;
  logic [ogb_pkg::NUM_W-1:0] num;
  logic [ogb_pkg::DEN_W-1:0] den;
  logic [ogb_pkg::LR_W-1:0]  lhs;
  logic [ogb_pkg::LR_W-1:0]  rhs;
  logic [ogb_pkg::NUM_W-1:0] bnum;
  logic [ogb_pkg::DEN_W-1:0] bden;
  logic [7:0]                bk;
  logic                      res_kind;
  logic [7:0]                res_value;
  logic                      res_ovf;

  logic [ogb_pkg::NUM_W-1:0]  mcand;
  logic [ogb_pkg::AB_W-1:0]   mplier;
  logic                       mul_busy;
  logic                       mul_done;
  logic [ogb_pkg::PROD_W-1:0] product;
  logic [ogb_pkg::CNT_W-1:0]  w_hi;

  assign w_hi    = total - w;
  assign d       = (a >= b) ? (a - b) : (b - a);
  assign rd_addr = cmd.acc_rd ? ogb_pkg::BIN_W'(pixel) : cmd.addr;
  assign we      = cmd.clr_wr || (cmd.acc_wr && (total != ogb_pkg::CNT_CAP));
  assign wr_addr = cmd.clr_wr ? cmd.addr : pix_reg;
  assign wr_data = cmd.clr_wr ? '0 : (rd_data + 1'b1);

  always_ff @(posedge clk) begin
    if (we) begin
      hist[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= hist[rd_addr];
    end
    if (cmd.acc_rd) begin
      pix_reg <= ogb_pkg::BIN_W'(pixel);
    end
  end

  always_comb begin
    mcand  = '0;
    mplier = '0;
    unique case (cmd.mul_op)
      ogb_pkg::MUL_A: begin
        mcand  = ogb_pkg::NUM_W'(t_sum - s);
        mplier = ogb_pkg::AB_W'(w);
      end
      ogb_pkg::MUL_B: begin
        mcand  = ogb_pkg::NUM_W'(s);
        mplier = ogb_pkg::AB_W'(w_hi);
      end
      ogb_pkg::MUL_NUM: begin
        mcand  = ogb_pkg::NUM_W'(d);
        mplier = d;
      end
      ogb_pkg::MUL_DEN: begin
        mcand  = ogb_pkg::NUM_W'(w);
        mplier = ogb_pkg::AB_W'(w_hi);
      end
      ogb_pkg::MUL_LHS: begin
        mcand  = num;
        mplier = ogb_pkg::AB_W'(bden);
      end
      ogb_pkg::MUL_RHS: begin
        mcand  = bnum;
        mplier = ogb_pkg::AB_W'(den);
      end
      default: begin
        mcand  = '0;
        mplier = '0;
      end
    endcase
  end

  ogb_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .mcand  (mcand),
    .mplier (mplier),
    .busy   (mul_busy),
    .done   (mul_done),
    .product(product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      sat   <= 1'b0;
      thr   <= '0;
    end else if (cmd.acc_wr) begin
      if (total == ogb_pkg::CNT_CAP) begin
        sat <= 1'b1;
      end else begin
        total <= total + 1'b1;
      end
    end else if (cmd.thr_res) begin
      thr   <= bk;
      total <= '0;
      sat   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.t_clr) begin
      t_sum <= '0;
    end else if (cmd.t_add) begin
      t_sum <= t_sum + ogb_pkg::SUM_W'(ogb_pkg::SUM_W'(cmd.addr) * ogb_pkg::SUM_W'(rd_data));
    end
    if (cmd.s_init) begin
      w    <= '0;
      s    <= '0;
      bnum <= '0;
      bden <= ogb_pkg::DEN_W'(1);
      bk   <= '0;
    end else if (cmd.s_add) begin
      w <= w + rd_data;
      s <= s + ogb_pkg::SUM_W'(ogb_pkg::SUM_W'(cmd.addr) * ogb_pkg::SUM_W'(rd_data));
    end else if (cmd.cmp_upd && (lhs > rhs)) begin
      bnum <= num;
      bden <= den;
      bk   <= 8'(cmd.addr);
    end
    if (cmd.mul_cap) begin
      unique case (cmd.mul_op)
        ogb_pkg::MUL_A:   a   <= product[ogb_pkg::AB_W-1:0];
        ogb_pkg::MUL_B:   b   <= product[ogb_pkg::AB_W-1:0];
        ogb_pkg::MUL_NUM: num <= product[ogb_pkg::NUM_W-1:0];
        ogb_pkg::MUL_DEN: den <= product[ogb_pkg::DEN_W-1:0];
        ogb_pkg::MUL_LHS: lhs <= product[ogb_pkg::LR_W-1:0];
        ogb_pkg::MUL_RHS: rhs <= product[ogb_pkg::LR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bin_res) begin
      res_kind  <= ogb_pkg::KIND_BIN;
      res_value <= (pixel < thr) ? 8'd0 : 8'd255;
      res_ovf   <= 1'b0;
    end else if (cmd.thr_res) begin
      res_kind  <= ogb_pkg::KIND_ACC;
      res_value <= bk;
      res_ovf   <= sat;
    end
    if (cmd.out_load) begin
      out_kind     <= res_kind;
      out_value    <= res_value;
      out_overflow <= res_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign st.skip     = (w == '0) || (w == total);
  assign st.mul_done = mul_done;
  assign st.mul_busy = mul_busy;
  assign st.out_free = !out_valid || out_ready;

endmodule

[rtl/ogb_ctrl.sv]
// ----------------------------------------------------------------------------
// Otsu binarizer controller
// Sequences histogram updates, the threshold scan, clearing and result output.
// ----------------------------------------------------------------------------
`include "otsu_gray_binarize_macros.svh"

module ogb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic               in_last,
  output ogb_pkg::ogb_cmd_t  cmd,
  input  ogb_pkg::ogb_stat_t st
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ACCW  = 4'd2;
  localparam logic [3:0] S_TRD   = 4'd3;
  localparam logic [3:0] S_TADD  = 4'd4;
  localparam logic [3:0] S_SRD   = 4'd5;
  localparam logic [3:0] S_SADD  = 4'd6;
  localparam logic [3:0] S_SCHK  = 4'd7;
  localparam logic [3:0] S_MGO   = 4'd8;
  localparam logic [3:0] S_MWAIT = 4'd9;
  localparam logic [3:0] S_CMP   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;

  logic [3:0]                state;
  logic [3:0]                state_next;
  logic [ogb_pkg::BIN_W-1:0] k;
  logic [ogb_pkg::BIN_W-1:0] k_next;
  logic [2:0]                op;
  logic [2:0]                op_next;
  logic                      last_r;
  logic                      last_r_next;
  logic                      to_clr;
  logic                      to_clr_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.addr    = k;
    cmd.mul_op  = op;
    state_next  = state;
    k_next      = k;
    op_next     = op;
    last_r_next = last_r;
    to_clr_next = to_clr;
    unique case (state)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (k == ogb_pkg::BIN_LAST) begin
          k_next     = '0;
          state_next = S_IDLE;
        end else begin
          k_next = k + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == ogb_pkg::KIND_BIN) begin
            cmd.bin_res = 1'b1;
            to_clr_next = 1'b0;
            state_next  = S_EMIT;
          end else begin
            cmd.acc_rd  = 1'b1;
            cmd.rd_en   = 1'b1;
            last_r_next = in_last;
            state_next  = S_ACCW;
          end
        end
      end
      S_ACCW: begin
        cmd.acc_wr = 1'b1;
        if (last_r) begin
          cmd.t_clr  = 1'b1;
          k_next     = '0;
          state_next = S_TRD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_TRD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_TADD;
      end
      S_TADD: begin
        cmd.t_add = 1'b1;
        if (k == ogb_pkg::BIN_LAST) begin
          cmd.s_init = 1'b1;
          k_next     = '0;
          state_next = S_SRD;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_TRD;
        end
      end
      S_SRD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SADD;
      end
      S_SADD: begin
        cmd.s_add  = 1'b1;
        state_next = S_SCHK;
      end
      S_SCHK: begin
        if (st.skip) begin
          if (k == ogb_pkg::BIN_LAST) begin
            state_next = S_FIN;
          end else begin
            k_next     = k + 1'b1;
            state_next = S_SRD;
          end
        end else begin
          op_next    = ogb_pkg::MUL_A;
          state_next = S_MGO;
        end
      end
      S_MGO: begin
        cmd.mul_start = 1'b1;
        state_next    = S_MWAIT;
      end
      S_MWAIT: begin
        if (st.mul_done) begin
          cmd.mul_cap = 1'b1;
          if (op == ogb_pkg::MUL_RHS) begin
            state_next = S_CMP;
          end else begin
            op_next    = op + 1'b1;
            state_next = S_MGO;
          end
        end
      end
      S_CMP: begin
        cmd.cmp_upd = 1'b1;
        if (k == ogb_pkg::BIN_LAST) begin
          state_next = S_FIN;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_SRD;
        end
      end
      S_FIN: begin
        cmd.thr_res = 1'b1;
        to_clr_next = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (to_clr) begin
            k_next     = '0;
            state_next = S_CLR;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLR;
      k      <= '0;
      op     <= ogb_pkg::MUL_A;
      last_r <= 1'b0;
      to_clr <= 1'b0;
    end else begin
      state  <= state_next;
      k      <= k_next;
      op     <= op_next;
      last_r <= last_r_next;
      to_clr <= to_clr_next;
    end
  end

  // A request is never accepted twice in a row; each one is fully handled first.
  `OGB_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state != S_IDLE)
  `OGB_ASSERT_IMPL(a_start_idle, cmd.mul_start, !st.mul_busy)
  `OGB_ASSERT_IMPL(a_load_free, cmd.out_load, st.out_free)
  `OGB_ASSERT_IMPL(a_busy_started, $rose(st.mul_busy), $past(cmd.mul_start))

endmodule

[rtl/otsu_gray_binarize.sv]
// ----------------------------------------------------------------------------
// Otsu gray binarizer
// Builds a 256-bin histogram per frame, finds the Otsu threshold, binarizes.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the pixels channel. An accumulate request adds its
// pixel to the histogram unless the frame count has saturated. An accumulate
// request marked last also starts the threshold scan: a pass forms the level
// sum, then each bin is checked, and when it splits the frame into two
// non-empty classes the shared one-bit-per-cycle multiplier forms six products
// for it in turn.
// The threshold then appears on the results channel with the overflow flag,
// and a pass clears the histogram memory.
// A binarize request returns 0 or 255 against the stored threshold.
// One request is handled at a time.
// After reset the block clears the histogram before it accepts a request.
// Results sit in an output register; while the receiver stalls, a request
// that has a result to send waits with ready low until the register is free.
// ----------------------------------------------------------------------------
module otsu_gray_binarize (
  input  logic             clk,
  input  logic             rst,
  ogb_pix_if.sink          pixels,
  ogb_res_if.source        results
);

  ogb_pkg::ogb_cmd_t  cmd;
  ogb_pkg::ogb_stat_t st;

  ogb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(pixels.valid),
    .in_ready(pixels.ready),
    .in_kind (pixels.kind),
    .in_last (pixels.last),
    .cmd     (cmd),
    .st      (st)
  );

  ogb_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .pixel       (pixels.pixel),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_kind    (results.result_kind),
    .out_value   (results.value),
    .out_overflow(results.overflow)
  );

endmodule
